// File: sv/cbd_pkg.sv
// Shared types and constants for the chunked body decoder.
`timescale 1ns / 1ps
`default_nettype none
package cbd_pkg;

   // Result status codes
   localparam logic [1:0] ST_BUSY      = 2'd0;
   localparam logic [1:0] ST_COMPLETE  = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   // Characters of interest
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_X  = 8'h78;

   // One classified body byte, as queued between front and back
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_zero;
      logic       is_space;
      logic       is_cr;
      logic       is_lf;
      logic       is_sign;
      logic       is_minus;
      logic       is_x;
   } item_type;

endpackage
`default_nettype wire

// File: sv/cbd_req_if.sv
// Input channel: raw body bytes with end-of-body mark.
`timescale 1ns / 1ps
`default_nettype none
interface cbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_body;

   modport source (output valid, output in_byte, output end_of_body, input ready);
   modport sink   (input valid, input in_byte, input end_of_body, output ready);
endinterface
`default_nettype wire

// File: sv/cbd_rsp_if.sv
// Result channel: decoded payload byte and body status.
`timescale 1ns / 1ps
`default_nettype none
interface cbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic [1:0] status;
   logic       finished;

   modport source (output valid, output out_byte, output out_valid, output status,
                   output finished, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input status,
                   input finished, output ready);
endinterface
`default_nettype wire

// File: sv/cbd_front.sv
// Front end: accepts body bytes, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module cbd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   cbd_req_if.sink                req_chan,
   output cbd_pkg::item_type      req_item,
   output logic                   req_item_valid,
   input  wire logic              req_item_pop
);
   import cbd_pkg::*;

   localparam int unsigned DEPTH = 2;

   item_type   queue_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   cls;

   always_comb begin
      logic [7:0] b;
      b = req_chan.in_byte;
      cls = '0;
      cls.data     = b;
      cls.last     = req_chan.end_of_body;
      cls.is_cr    = (b == CH_CR);
      cls.is_lf    = (b == CH_LF);
      cls.is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) ||
                     (b == CH_FF) || (b == CH_CR);
      cls.is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
      cls.is_minus = (b == CH_MINUS);
      cls.is_x     = (b == CH_LO_X) || (b == CH_UP_X);
      cls.is_zero  = (b == CH_ZERO);
      if (b inside {[CH_ZERO:CH_NINE]}) begin
         cls.is_hex  = 1'b1;
         cls.hex_val = b[3:0];
      end else if (b inside {[CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]}) begin
         // 'a'/'A' low nibble is 1
         cls.is_hex  = 1'b1;
         cls.hex_val = b[3:0] + 4'd9;
      end
   end

   assign req_chan.ready = (count_ff != 2'(DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign req_item_valid = (count_ff != 2'd0);
   assign req_item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 1'(push);
      rd_ptr_in = rd_ptr_ff + 1'(req_item_pop);
      count_in  = count_ff + 2'(push) - 2'(req_item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue count beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      req_item_pop |-> count_ff != 2'd0)
      else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !req_item_pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not follow a lone push");
`endif
endmodule
`default_nettype wire

// File: sv/cbd_back.sv
// Back end: chunk parser state machine and registered result stage.
`timescale 1ns / 1ps
`default_nettype none
module cbd_back #(
   parameter int unsigned SIZE_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cbd_pkg::item_type req_item,
   input  wire logic              req_item_valid,
   output logic                   req_item_pop,
   cbd_rsp_if.source              rsp_chan
);
   import cbd_pkg::*;

   localparam logic [3:0] PH_LEAD    = 4'd0;
   localparam logic [3:0] PH_SIGNED  = 4'd1;
   localparam logic [3:0] PH_ZERO    = 4'd2;
   localparam logic [3:0] PH_PREFIX  = 4'd3;
   localparam logic [3:0] PH_DIGITS  = 4'd4;
   localparam logic [3:0] PH_TAIL    = 4'd5;
   localparam logic [3:0] PH_DATA    = 4'd6;
   localparam logic [3:0] PH_DATA_CR = 4'd7;
   localparam logic [3:0] PH_DATA_LF = 4'd8;
   localparam logic [3:0] PH_DONE    = 4'd9;
   localparam logic [3:0] PH_ERROR   = 4'd10;

   localparam logic [SIZE_BITS-1:0] REM_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

   logic [3:0]           phase_ff, phase_in;
   logic [SIZE_BITS-1:0] rem_ff, rem_in;
   logic                 minus_ff, minus_in;
   logic                 digit_ff, digit_in;
   logic                 pend_ff, pend_in;

   logic                 rsp_valid_ff;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           status_ff, status_in;
   logic                 finished_ff;

   // A held CR that turns out not to start the line end acts as a line character
   function automatic logic [3:0] cr_phase(input logic [3:0] ph);
      logic [3:0] r;
      r = ph;
      case (ph)
         PH_SIGNED:                      r = PH_ERROR;
         PH_ZERO, PH_PREFIX, PH_DIGITS:  r = PH_TAIL;
         default:                        r = ph;
      endcase
      return r;
   endfunction

   assign req_item_pop = req_item_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      logic use_char;
      phase_in = phase_ff;
      rem_in   = rem_ff;
      minus_in = minus_ff;
      digit_in = digit_ff;
      pend_in  = pend_ff;
      use_char = 1'b1;
      out_valid_in = 1'b0;

      if (phase_ff <= PH_TAIL) begin
         if (pend_ff) begin
            pend_in = 1'b0;
            if (req_item.is_lf) begin
               use_char = 1'b0;
               if (phase_ff == PH_LEAD || phase_ff == PH_SIGNED || !digit_ff) begin
                  phase_in = PH_ERROR;
               end else if (rem_ff == '0) begin
                  phase_in = PH_DONE;
               end else if (minus_ff) begin
                  phase_in = PH_ERROR;
               end else begin
                  phase_in = PH_DATA;
               end
               minus_in = 1'b0;
               digit_in = 1'b0;
            end else begin
               phase_in = cr_phase(phase_ff);
            end
         end
         if (use_char && phase_in <= PH_TAIL) begin
            if (req_item.is_cr) begin
               pend_in = 1'b1;
            end else begin
               case (phase_in)
                  PH_LEAD, PH_SIGNED: begin
                     if (phase_in == PH_LEAD && req_item.is_space) begin
                        phase_in = PH_LEAD;
                     end else if (phase_in == PH_LEAD && req_item.is_sign) begin
                        minus_in = req_item.is_minus;
                        phase_in = PH_SIGNED;
                     end else if (req_item.is_hex) begin
                        digit_in = 1'b1;
                        rem_in   = {{(SIZE_BITS-4){1'b0}}, req_item.hex_val};
                        phase_in = req_item.is_zero ? PH_ZERO : PH_DIGITS;
                     end else begin
                        phase_in = PH_ERROR;
                     end
                  end
                  PH_ZERO, PH_PREFIX, PH_DIGITS: begin
                     if (phase_in == PH_ZERO && req_item.is_x) begin
                        phase_in = PH_PREFIX;
                     end else if (req_item.is_hex) begin
                        if (rem_in[SIZE_BITS-1 -: 4] != 4'd0) begin
                           phase_in = PH_ERROR;
                        end else begin
                           rem_in   = {rem_in[SIZE_BITS-5:0], req_item.hex_val};
                           phase_in = PH_DIGITS;
                        end
                     end else begin
                        phase_in = PH_TAIL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end else begin
         case (phase_ff)
            PH_DATA: begin
               out_valid_in = 1'b1;
               rem_in       = rem_ff - REM_ONE;
               if (rem_ff == REM_ONE) begin
                  phase_in = PH_DATA_CR;
               end
            end
            PH_DATA_CR: phase_in = req_item.is_cr ? PH_DATA_LF : PH_ERROR;
            PH_DATA_LF: phase_in = req_item.is_lf ? PH_LEAD : PH_ERROR;
            default: begin
            end
         endcase
      end

      if (phase_in == PH_DONE) begin
         status_in = ST_COMPLETE;
      end else if (phase_in == PH_ERROR || req_item.last) begin
         status_in = ST_MALFORMED;
      end else begin
         status_in = ST_BUSY;
      end
      out_byte_in = out_valid_in ? req_item.data : 8'd0;

      // next body starts from scratch
      if (req_item.last) begin
         phase_in = PH_LEAD;
         rem_in   = '0;
         minus_in = 1'b0;
         digit_in = 1'b0;
         pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         rem_ff       <= '0;
         minus_ff     <= 1'b0;
         digit_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_item_pop) begin
            phase_ff <= phase_in;
            rem_ff   <= rem_in;
            minus_ff <= minus_in;
            digit_ff <= digit_in;
            pend_ff  <= pend_in;
         end
         if (req_item_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_item_pop) begin
         out_byte_ff  <= out_byte_in;
         out_valid_ff <= out_valid_in;
         status_ff    <= status_in;
         finished_ff  <= req_item.last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.out_valid = out_valid_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.finished  = finished_ff;

`ifndef ASSERT_OFF
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      req_item_pop && req_item.last |=> phase_ff == PH_LEAD && rem_ff == '0 && !pend_ff)
      else $error("state not cleared after end of body");
   a_complete_phase: assert property (@(posedge clock) disable iff (reset)
      req_item_pop && !req_item.last |=>
         (rsp_chan.status == ST_COMPLETE) == (phase_ff == PH_DONE))
      else $error("complete status does not match done phase");
   a_payload_from_data: assert property (@(posedge clock) disable iff (reset)
      req_item_pop |=> rsp_chan.out_valid == ($past(phase_ff) == PH_DATA))
      else $error("payload item outside data phase");
`endif
endmodule
`default_nettype wire

// File: sv/chunked_body_decoder.sv
// An accepted item is written to the queue, then popped through the parser into the result register.
// Throughput: one item per cycle unless the result channel stalls; the parser state machine handles one byte per cycle.
// A 2-entry queue between classifier and parser lets input and result stall independently.
// Reset: synchronous, active high; parser returns to the start of a size line, queue empties.
// No clearing pass: the block is ready for items as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module chunked_body_decoder #(
   parameter int unsigned SIZE_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   cbd_req_if.sink   req_chan,
   cbd_rsp_if.source rsp_chan
);
   import cbd_pkg::*;

   item_type req_item;
   logic     req_item_valid;
   logic     req_item_pop;

   cbd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .req_item       (req_item),
      .req_item_valid (req_item_valid),
      .req_item_pop   (req_item_pop)
   );

   cbd_back #(
      .SIZE_BITS (SIZE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .req_item       (req_item),
      .req_item_valid (req_item_valid),
      .req_item_pop   (req_item_pop),
      .rsp_chan       (rsp_chan)
   );
endmodule
`default_nettype wire
